@@ hw/rtl/oipa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package oipa_pkg;

   // Pool geometry
   localparam int POOL_SIZE = 256;
   localparam int ADDR_W    = $clog2(POOL_SIZE);
   localparam int CNT_W     = $clog2(POOL_SIZE + 1);
   localparam int ID_W      = 16;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 3;

   // Packed beat widths, padded to whole bytes
   localparam int REQ_TDATA_W = ((OP_W + ID_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((ID_W + STATUS_W + CNT_W + 7) / 8) * 8;

   // Register file
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ID = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ID = 2'd1;

   // Reset values of the range registers
   localparam logic [ID_W-1:0] MIN_ID_RST = 16'd0;
   localparam logic [ID_W-1:0] MAX_ID_RST = 16'd255;

   // Operation codes
   localparam logic [OP_W-1:0] OP_ALLOC_NEXT = 2'd0;
   localparam logic [OP_W-1:0] OP_ALLOC_AT   = 2'd1;
   localparam logic [OP_W-1:0] OP_FREE       = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 3'd0,
      STATUS_EMPTY    = 3'd1,
      STATUS_RANGE    = 3'd2,
      STATUS_INUSE    = 3'd3,
      STATUS_NOTALLOC = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_REFILL,
      ST_IDLE,
      ST_HEAD_RD,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

@@ hw/rtl/oipa_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data
module oipa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/ordered_id_pool_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Ports                                 Content
// req      in   req_tvalid/req_tready/req_tdata       op, req_id
// rsp      out  rsp_tvalid/rsp_tready/rsp_tdata       out_id, status, free_count
// csr      in   csr_valid/csr_ready/csr_index/csr_data  min_id (0), max_id (1)
//
// Allocate-next reads the head entry; a rejected request goes straight to the result.
// Allocate-at and free search the list with a read and a compare state per entry visited,
// through the whole list when the id is absent; allocate-at then closes the gap behind
// the hit with a read and a write state per entry; the search/shift sequencer uses the
// single read and single write port of the list RAM. After reset and after every register
// write the list is refilled, one entry a cycle; no request is taken meanwhile.
// A finished result waits in the output register while the next beat is taken.
module ordered_id_pool_allocator (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // [1:0] op, [17:2] req_id, [23:18] zero
   input  wire logic [oipa_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [15:0] out_id, [18:16] status, [27:19] free_count, [31:28] zero
   output logic      [oipa_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [oipa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [oipa_pkg::ID_W-1:0]            csr_data
);

   import oipa_pkg::*;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     k_ff, k_in;
   logic [ADDR_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [ID_W-1:0]      min_ff, min_in;
   logic [ID_W-1:0]      max_ff, max_in;
   logic [ID_W-1:0]      range_hi_ff, range_hi_in;
   logic                 range_valid_ff, range_valid_in;
   logic [CNT_W-1:0]     span_ff, span_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [ID_W-1:0]      res_id_ff, res_id_in;
   status_type           res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic                 req_acc;
   logic                 csr_acc;
   logic [OP_W-1:0]      req_op;
   logic [ID_W-1:0]      req_id;
   logic                 req_in_range;
   logic [ID_W-1:0]      new_min;
   logic [ID_W-1:0]      new_max;
   logic [ID_W-1:0]      new_diff;

   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [ID_W-1:0]      wr_data;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ID_W-1:0]      rd_data;

   // Beat unpacking
   assign req_op  = req_tdata[OP_W-1:0];
   assign req_id  = req_tdata[OP_W+ID_W-1:OP_W];
   assign req_acc = req_tvalid && req_tready;
   assign csr_acc = csr_valid && csr_ready;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   assign req_in_range = range_valid_ff && (req_id >= min_ff) && (req_id <= range_hi_ff);

   // Candidate range registers for a configuration write
   assign new_min  = (csr_index == CSR_MIN_ID) ? csr_data : min_ff;
   assign new_max  = (csr_index == CSR_MAX_ID) ? csr_data : max_ff;
   assign new_diff = new_max - new_min;

   // Free list storage, kept as a ring from head_ff
   oipa_ram #(
      .WIDTH (ID_W),
      .DEPTH (POOL_SIZE)
   ) u_list (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      k_in           = k_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      min_in         = min_ff;
      max_in         = max_ff;
      range_hi_in    = range_hi_ff;
      range_valid_in = range_valid_ff;
      span_in        = span_ff;
      op_in          = op_ff;
      id_in          = id_ff;
      res_id_in      = res_id_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_id_in      = rsp_id_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      wr_en          = 1'b0;
      wr_addr        = head_ff + k_ff[ADDR_W-1:0];
      wr_data        = id_ff;
      rd_addr        = head_ff + k_ff[ADDR_W-1:0];

      unique case (state_ff)
         ST_REFILL: begin
            // Write min_id + k into slot k
            if (k_ff == span_ff) begin
               state_in = ST_IDLE;
            end else begin
               wr_en   = 1'b1;
               wr_addr = k_ff[ADDR_W-1:0];
               wr_data = min_ff + ID_W'(k_ff);
               k_in    = k_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            rd_addr = head_ff;
            if (req_acc) begin
               op_in = req_op;
               id_in = req_id;
               k_in  = '0;
               priority if (req_op == OP_ALLOC_NEXT) begin
                  if (count_ff == '0) begin
                     res_id_in     = '0;
                     res_status_in = STATUS_EMPTY;
                     state_in      = ST_DONE;
                  end else begin
                     state_in = ST_HEAD_RD;
                  end
               end else if (req_op == OP_ALLOC_AT || req_op == OP_FREE) begin
                  if (!req_in_range) begin
                     res_id_in     = (req_op == OP_FREE) ? req_id : '0;
                     res_status_in = STATUS_RANGE;
                     state_in      = ST_DONE;
                  end else begin
                     state_in = ST_SRCH_RD;
                  end
               end else begin
                  // undefined op: no change
                  res_id_in     = '0;
                  res_status_in = STATUS_RANGE;
                  state_in      = ST_DONE;
               end
            end
         end

         ST_HEAD_RD: begin
            res_id_in     = rd_data;
            res_status_in = STATUS_OK;
            head_in       = head_ff + 1'b1;
            count_in      = count_ff - 1'b1;
            state_in      = ST_DONE;
         end

         ST_SRCH_RD: begin
            if (k_ff == count_ff) begin
               // id not in the list
               if (op_ff == OP_ALLOC_AT) begin
                  res_id_in     = '0;
                  res_status_in = STATUS_INUSE;
               end else begin
                  res_id_in     = id_ff;
                  res_status_in = STATUS_OK;
                  if (count_ff < CNT_W'(POOL_SIZE)) begin
                     wr_en    = 1'b1;
                     wr_addr  = head_ff + count_ff[ADDR_W-1:0];
                     count_in = count_ff + 1'b1;
                  end
               end
               state_in = ST_DONE;
            end else begin
               state_in = ST_SRCH_CMP;
            end
         end

         ST_SRCH_CMP: begin
            if (rd_data == id_ff) begin
               res_id_in = id_ff;
               if (op_ff == OP_FREE) begin
                  res_status_in = STATUS_NOTALLOC;
                  state_in      = ST_DONE;
               end else if (k_ff == '0) begin
                  // hit at the head: just advance it
                  res_status_in = STATUS_OK;
                  head_in       = head_ff + 1'b1;
                  count_in      = count_ff - 1'b1;
                  state_in      = ST_DONE;
               end else begin
                  res_status_in = STATUS_OK;
                  state_in      = ST_SHIFT_RD;
               end
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_SRCH_RD;
            end
         end

         ST_SHIFT_RD: begin
            // Pull entry k+1 down into slot k
            rd_addr = head_ff + k_ff[ADDR_W-1:0] + 1'b1;
            if (k_ff + 1'b1 >= count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_SHIFT_WR;
            end
         end

         ST_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            k_in     = k_ff + 1'b1;
            state_in = ST_SHIFT_RD;
         end

         ST_DONE: begin
            // Hand over to the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = res_id_ff;
               rsp_status_in = res_status_ff;
               rsp_count_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Register write: new range, restart the refill
      if (csr_acc && (csr_index == CSR_MIN_ID || csr_index == CSR_MAX_ID)) begin
         min_in      = new_min;
         max_in      = new_max;
         range_hi_in = new_min;
         head_in     = '0;
         k_in        = '0;
         state_in    = ST_REFILL;
         if (new_max < new_min) begin
            range_valid_in = 1'b0;
            span_in        = '0;
         end else if (new_diff >= ID_W'(POOL_SIZE - 1)) begin
            range_valid_in = 1'b1;
            span_in        = CNT_W'(POOL_SIZE);
            range_hi_in    = new_min + ID_W'(POOL_SIZE - 1);
         end else begin
            range_valid_in = 1'b1;
            span_in        = CNT_W'(new_diff) + 1'b1;
            range_hi_in    = new_max;
         end
         count_in = span_in;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_REFILL;
         k_ff           <= '0;
         head_ff        <= '0;
         count_ff       <= CNT_W'(POOL_SIZE);
         min_ff         <= MIN_ID_RST;
         max_ff         <= MAX_ID_RST;
         range_hi_ff    <= MAX_ID_RST;
         range_valid_ff <= 1'b1;
         span_ff        <= CNT_W'(POOL_SIZE);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         k_ff           <= k_in;
         head_ff        <= head_in;
         count_ff       <= count_in;
         min_ff         <= min_in;
         max_ff         <= max_in;
         range_hi_ff    <= range_hi_in;
         range_valid_ff <= range_valid_in;
         span_ff        <= span_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      res_id_ff     <= res_id_in;
      res_status_ff <= res_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - ID_W - STATUS_W - CNT_W){1'b0}},
                        rsp_count_ff, rsp_status_ff, rsp_id_ff};

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(POOL_SIZE))
      else $error("free count above pool size");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("request taken while another is at work");

   a_shift_inside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT_RD || state_ff == ST_SHIFT_WR) |-> (k_ff < count_ff))
      else $error("gap closing beyond the list tail");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_EMPTY) |-> (rsp_count_ff == '0))
      else $error("empty status with free entries left");

   a_refill_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REFILL) |-> (k_ff <= span_ff && count_ff == span_ff))
      else $error("refill counter out of step");
`endif

endmodule

`default_nettype wire
